>>> src/ffst_pkg.sv
// Shared types and codes for the first-free slot table.
`timescale 1ns / 1ps

package ffst_pkg;

  // Operation codes carried on the op port
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Status codes returned with every result
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FREE  = 2'd3
  } status_t;

  localparam int unsigned IDX_W    = 6;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned DATA_W   = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // One accepted command beat handed to the mark unit
  typedef struct packed {
    logic                   go;
    op_t                    op;
    logic [IDX_W-1:0]       slot_index;
  } ffst_cmd_t;

  // Decision of the mark unit for the accepted beat
  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       result_index;
    logic                   slot_used;
  } ffst_res_t;

endpackage

>>> src/ffst_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module ffst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/ffst_marks.sv
// Used marks, live count, first-free search and limit sweep.
`timescale 1ns / 1ps

module ffst_marks #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffst_pkg::ffst_cmd_t                 cmd,
  input  logic [ffst_pkg::LIMIT_W-1:0]        slot_limit,
  input  logic                                cfg_we,
  output ffst_pkg::ffst_res_t                 res,
  output logic                                busy,
  output logic                                ram_we,
  output logic [$clog2(SLOTS)-1:0]            ram_addr,
  output logic [$clog2(SLOTS+1)-1:0]          count
);

  localparam int unsigned IW  = $clog2(SLOTS);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned LW  = (CW > ffst_pkg::LIMIT_W) ? CW : ffst_pkg::LIMIT_W;
  localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);
  localparam logic [IW-1:0] LAST    = IW'(SLOTS - 1);

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  state_t             state, state_next;
  logic [IW-1:0]      ptr, ptr_next;
  logic [SLOTS-1:0]   marks, marks_next;
  logic [CW-1:0]      count_next;

  logic [LW-1:0]      lim_ext, lim_act, idx_ext;
  logic               idx_ok, mark_at, any_free;
  logic [IW-1:0]      idx, first_idx;
  logic [SLOTS-1:0]   below, free, first;

  // Clamp the limit to the table size
  assign lim_ext = LW'(slot_limit);
  assign lim_act = (lim_ext > SLOTS_L) ? SLOTS_L : lim_ext;
  assign idx_ext = LW'(cmd.slot_index);
  assign idx_ok  = idx_ext < lim_act;
  assign idx     = IW'(cmd.slot_index);
  assign mark_at = marks[idx];

  // Find the lowest free slot below the limit
  always_comb begin
    first_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      below[i] = LW'(i) < lim_act;
    end
    free     = ~marks & below;
    any_free = |free;
    first    = free & (~free + SLOTS'(1));
    for (int i = 0; i < SLOTS; i++) begin
      if (first[i]) begin
        first_idx = first_idx | IW'(i);
      end
    end
  end

  // Decide the command and the sweep step
  always_comb begin
    res.status       = ffst_pkg::ST_OK;
    res.result_index = '0;
    res.slot_used    = 1'b0;
    marks_next       = marks;
    count_next       = count;
    state_next       = state;
    ptr_next         = ptr;
    ram_we           = 1'b0;
    ram_addr         = idx;

    if (cmd.go) begin
      case (cmd.op)
        ffst_pkg::OP_APPEND: begin
          ram_addr = first_idx;
          if (any_free) begin
            marks_next       = marks | first;
            count_next       = count + CW'(1);
            ram_we           = 1'b1;
            res.result_index = ffst_pkg::IDX_W'(first_idx);
          end else begin
            res.status = ffst_pkg::ST_FULL;
          end
        end
        ffst_pkg::OP_REMOVE: begin
          res.result_index = cmd.slot_index;
          if (!idx_ok) begin
            res.status = ffst_pkg::ST_RANGE;
          end else if (!mark_at) begin
            res.status = ffst_pkg::ST_FREE;
          end else begin
            marks_next[idx] = 1'b0;
            count_next      = count - CW'(1);
          end
        end
        ffst_pkg::OP_GET: begin
          res.result_index = cmd.slot_index;
          if (!idx_ok) begin
            res.status = ffst_pkg::ST_RANGE;
          end else begin
            res.slot_used = mark_at;
          end
        end
        default: begin
          marks_next = '0;
          count_next = '0;
        end
      endcase
    end

    case (state)
      S_IDLE: begin
        if (cfg_we) begin
          state_next = S_SWEEP;
          ptr_next   = '0;
        end
      end
      S_SWEEP: begin
        // Drop slots at or above the new limit
        if (LW'(ptr) >= lim_act && marks[ptr]) begin
          marks_next[ptr] = 1'b0;
          count_next      = count - CW'(1);
        end
        if (ptr == LAST) begin
          state_next = S_IDLE;
        end else begin
          ptr_next = ptr + IW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state == S_SWEEP);

  // Hold state, marks and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      marks <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
      marks <= marks_next;
      count <= count_next;
    end
  end

endmodule

>>> src/first_free_slot_table.sv
// Top level of the first-free slot table.
`timescale 1ns / 1ps
//
// Command channel: a beat (op, slot_index, item_data) is taken at a rising
// edge with start high and busy low. Ops: append into the lowest free slot
// below slot_limit, remove a slot, get a slot, clear all slots.
// Result channel: done is high for exactly one cycle, in the cycle after the
// command beat, with status, result_index, read_data, slot_used and
// live_count. The receiver cannot stall; every result must be taken then.
// Throughput: one command per cycle while busy is low. Used marks sit in
// flops and feed a find-first-set encoder, so the free slot is picked in the
// accept cycle; slot data lives in a single-port RAM whose registered read
// supplies read_data in the result cycle.
// Configuration: slot_limit is written through cfg_valid/cfg_ready/cfg_data.
// Each write starts a sweep through the slots that frees those at or above the
// new limit; busy is high and cfg_ready low during the sweep.
// Reset: all slots free, live count zero, slot_limit 64, no sweep pending.

module first_free_slot_table #(
  parameter int unsigned SLOTS      = 64,
  parameter int unsigned ITEM_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         op,
  input  logic [ffst_pkg::IDX_W-1:0]         slot_index,
  input  logic [ffst_pkg::DATA_W-1:0]        item_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffst_pkg::LIMIT_W-1:0]       cfg_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic [ffst_pkg::IDX_W-1:0]         result_index,
  output logic [ffst_pkg::DATA_W-1:0]        read_data,
  output logic                               slot_used,
  output logic [ffst_pkg::COUNT_W-1:0]       live_count
);

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  logic [ffst_pkg::LIMIT_W-1:0] slot_limit;
  ffst_pkg::ffst_cmd_t          cmd;
  ffst_pkg::ffst_res_t          res;
  logic                         cfg_we;
  logic                         ram_we;
  logic [IW-1:0]                ram_addr;
  logic [ITEM_WIDTH-1:0]        ram_q;
  logic [CW-1:0]                count;
  logic [63:0]                  q_ext;

  assign cmd.go         = start & ~busy;
  assign cmd.op         = ffst_pkg::op_t'(op);
  assign cmd.slot_index = slot_index;
  assign cfg_ready      = ~busy;
  assign cfg_we         = cfg_valid & cfg_ready;

  ffst_marks #(
    .SLOTS(SLOTS)
  ) u_marks (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .slot_limit (slot_limit),
    .cfg_we     (cfg_we),
    .res        (res),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .count      (count)
  );

  ffst_ram #(
    .WIDTH(ITEM_WIDTH),
    .DEPTH(SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ITEM_WIDTH'(item_data)),
    .rdata (ram_q)
  );

  // Hold the limit register and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= ffst_pkg::LIMIT_RESET;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        slot_limit <= cfg_data;
      end
      done <= cmd.go;
    end
  end

  // Capture the result beat fields
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      status       <= res.status;
      result_index <= res.result_index;
      slot_used    <= res.slot_used;
    end
  end

  // Free slots read as zero
  assign q_ext      = 64'(ram_q);
  assign read_data  = slot_used ? q_ext[ffst_pkg::DATA_W-1:0] : '0;
  assign live_count = ffst_pkg::COUNT_W'(count);

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the first-free slot table.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned SLOT_COUNT  = 64;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned CALM_ITEMS  = 150;

  // One entry of the command stream: either a command beat or a slot_limit write
  typedef struct packed {
    logic                         is_cfg;
    ffst_pkg::op_t                op;
    logic [ffst_pkg::IDX_W-1:0]   idx;
    logic [ffst_pkg::DATA_W-1:0]  word;
    logic [ffst_pkg::LIMIT_W-1:0] limit;
  } table_beat_t;

  // Expected contents of one result beat
  typedef struct packed {
    ffst_pkg::status_t            status;
    logic [ffst_pkg::IDX_W-1:0]   index;
    logic [ffst_pkg::DATA_W-1:0]  data;
    logic                         used;
    logic [ffst_pkg::COUNT_W-1:0] count;
  } table_result_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [1:0]                   op = 2'd0;
  logic [ffst_pkg::IDX_W-1:0]   slot_index = '0;
  logic [ffst_pkg::DATA_W-1:0]  item_data = '0;
  logic                         cfg_valid = 1'b0;
  logic [ffst_pkg::LIMIT_W-1:0] cfg_data = '0;
  logic                         busy;
  logic                         cfg_ready;
  logic                         done;
  logic [1:0]                   status;
  logic [ffst_pkg::IDX_W-1:0]   result_index;
  logic [ffst_pkg::DATA_W-1:0]  read_data;
  logic                         slot_used;
  logic [ffst_pkg::COUNT_W-1:0] live_count;

  table_beat_t         beat_q[$];
  table_result_t       outcome_q[$];

  // Shadow copy of the table
  logic [SLOT_COUNT-1:0]        tbl_used;
  logic [ffst_pkg::DATA_W-1:0]  tbl_word [SLOT_COUNT];
  int unsigned                  tbl_count;
  logic [ffst_pkg::LIMIT_W-1:0] tbl_limit;

  int unsigned cycle_count = 0;
  int unsigned quiet = 0;
  int unsigned gap_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned limit_writes = 0;
  int unsigned op_seen [4];
  int unsigned status_seen [4];

  first_free_slot_table u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .slot_index   (slot_index),
    .item_data    (item_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .result_index (result_index),
    .read_data    (read_data),
    .slot_used    (slot_used),
    .live_count   (live_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned usable_slots(logic [ffst_pkg::LIMIT_W-1:0] lim);
    return (lim > SLOT_COUNT) ? SLOT_COUNT : lim;
  endfunction

  // Apply a slot_limit write: free everything at or above the new limit
  function automatic void apply_limit(logic [ffst_pkg::LIMIT_W-1:0] value);
    int unsigned i;
    tbl_limit = value;
    for (i = usable_slots(value); i < SLOT_COUNT; i++) begin
      if (tbl_used[i]) begin
        tbl_used[i] = 1'b0;
        tbl_word[i] = '0;
        tbl_count--;
      end
    end
  endfunction

  // Work out the result of one command and update the shadow table
  function automatic table_result_t table_outcome(ffst_pkg::op_t cmd,
                                                  logic [ffst_pkg::IDX_W-1:0] idx,
                                                  logic [ffst_pkg::DATA_W-1:0] word);
    table_result_t r;
    int unsigned   lim;
    int unsigned   i;
    r = '0;
    r.status = ffst_pkg::ST_OK;
    lim = usable_slots(tbl_limit);
    case (cmd)
      ffst_pkg::OP_APPEND: begin
        r.status = ffst_pkg::ST_FULL;
        for (i = 0; i < lim && r.status == ffst_pkg::ST_FULL; i++) begin
          if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_word[i] = word;
            tbl_count++;
            r.status = ffst_pkg::ST_OK;
            r.index = i[ffst_pkg::IDX_W-1:0];
          end
        end
      end
      ffst_pkg::OP_REMOVE: begin
        r.index = idx;
        if (idx >= lim) begin
          r.status = ffst_pkg::ST_RANGE;
        end else if (!tbl_used[idx]) begin
          r.status = ffst_pkg::ST_FREE;
        end else begin
          tbl_used[idx] = 1'b0;
          tbl_word[idx] = '0;
          tbl_count--;
        end
      end
      ffst_pkg::OP_GET: begin
        r.index = idx;
        if (idx >= lim) begin
          r.status = ffst_pkg::ST_RANGE;
        end else if (tbl_used[idx]) begin
          r.data = tbl_word[idx];
          r.used = 1'b1;
        end
      end
      default: begin
        tbl_used = '0;
        for (i = 0; i < SLOT_COUNT; i++) tbl_word[i] = '0;
        tbl_count = 0;
      end
    endcase
    r.count = tbl_count[ffst_pkg::COUNT_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] exp_val, logic [63:0] act_val);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, exp_val,
               act_val);
  endtask

  task automatic add_cmd(ffst_pkg::op_t cmd, logic [ffst_pkg::IDX_W-1:0] idx,
                         logic [ffst_pkg::DATA_W-1:0] word);
    table_beat_t b;
    b = '0;
    b.op = cmd;
    b.idx = idx;
    b.word = word;
    beat_q.push_back(b);
  endtask

  task automatic add_limit(logic [ffst_pkg::LIMIT_W-1:0] value);
    table_beat_t b;
    b = '0;
    b.is_cfg = 1'b1;
    b.limit = value;
    beat_q.push_back(b);
  endtask

  function automatic logic [ffst_pkg::DATA_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Any index in the full index range
  function automatic logic [ffst_pkg::IDX_W-1:0] any_index();
    int unsigned v;
    v = $urandom;
    return v[ffst_pkg::IDX_W-1:0];
  endfunction

  // Mostly indices inside the limit, some anywhere in the index range
  function automatic logic [ffst_pkg::IDX_W-1:0] pick_index(
      logic [ffst_pkg::LIMIT_W-1:0] lim);
    int unsigned n;
    int unsigned v;
    n = usable_slots(lim);
    if (n > 0 && $urandom_range(0, 9) != 0) v = $urandom_range(0, n - 1);
    else v = $urandom_range(0, SLOT_COUNT - 1);
    return v[ffst_pkg::IDX_W-1:0];
  endfunction

  // Write a limit, then a random mix leaning toward appends so the table fills
  task automatic random_phase(logic [ffst_pkg::LIMIT_W-1:0] lim, int unsigned n);
    int unsigned k;
    int unsigned r;
    add_limit(lim);
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      add_cmd(ffst_pkg::OP_APPEND, any_index(), pick_word());
      else if (r < 70) add_cmd(ffst_pkg::OP_REMOVE, pick_index(lim), pick_word());
      else if (r < 97) add_cmd(ffst_pkg::OP_GET, pick_index(lim), pick_word());
      else             add_cmd(ffst_pkg::OP_CLEAR, any_index(), pick_word());
    end
  endtask

  // Driver: predict on accepted beats, then present the next one
  always @(posedge clk) begin
    logic        cmd_taken;
    logic        cfg_taken;
    table_beat_t nb;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      gap_left <= 0;
      quiet <= 0;
    end else begin
      cmd_taken = start && !busy;
      cfg_taken = cfg_valid && cfg_ready;
      if (cmd_taken) begin
        outcome_q.push_back(table_outcome(ffst_pkg::op_t'(op), slot_index, item_data));
        op_seen[op]++;
      end
      if (cfg_taken) begin
        apply_limit(cfg_data);
        limit_writes++;
      end
      quiet <= start ? 0 : quiet + 1;
      if ((start && !cmd_taken) || (cfg_valid && !cfg_taken)) begin
        // hold the current beat
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (beat_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (beat_q[0].is_cfg) begin
        // write the limit only once the table has gone quiet
        start <= 1'b0;
        if (!start && quiet >= 3 && outcome_q.size() == 0) begin
          nb = beat_q.pop_front();
          cfg_data <= nb.limit;
          cfg_valid <= 1'b1;
        end else begin
          cfg_valid <= 1'b0;
        end
      end else begin
        nb = beat_q.pop_front();
        start <= 1'b1;
        op <= nb.op;
        slot_index <= nb.idx;
        item_data <= nb.word;
        cfg_valid <= 1'b0;
        if (beat_q.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
          gap_left <= $urandom_range(1, 14);
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    table_result_t e;
    if (!rst && done) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("unexpected result beat", 64'd0, 64'd1);
      end else begin
        e = outcome_q.pop_front();
        status_seen[e.status]++;
        if (status !== e.status)       note_mismatch("status", e.status, status);
        if (result_index !== e.index)  note_mismatch("result_index", e.index, result_index);
        if (read_data !== e.data)      note_mismatch("read_data", e.data, read_data);
        if (slot_used !== e.used)      note_mismatch("slot_used", e.used, slot_used);
        if (live_count !== e.count)    note_mismatch("live_count", e.count, live_count);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d beats unsent, %0d results outstanding",
               cycle_count, beat_q.size(), outcome_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    logic [ffst_pkg::LIMIT_W-1:0] lims [14];
    tbl_used = '0;
    for (k = 0; k < SLOT_COUNT; k++) tbl_word[k] = '0;
    tbl_count = 0;
    tbl_limit = ffst_pkg::LIMIT_RESET;
    for (k = 0; k < 4; k++) begin
      op_seen[k] = 0;
      status_seen[k] = 0;
    end

    // Single usable slot: full, range, not-in-use and free reads
    add_limit(7'd1);
    add_cmd(ffst_pkg::OP_APPEND, 6'd63, 32'hFFFF_FFFF);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'h0000_0000);
    add_cmd(ffst_pkg::OP_GET, 6'd0, 32'h0);
    add_cmd(ffst_pkg::OP_GET, 6'd63, 32'h0);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd63, 32'h0);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd0, 32'h0);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd0, 32'h0);
    add_cmd(ffst_pkg::OP_GET, 6'd0, 32'h0);
    add_cmd(ffst_pkg::OP_APPEND, 6'd42, 32'h0000_0000);
    add_cmd(ffst_pkg::OP_GET, 6'd0, 32'hFFFF_FFFF);
    add_cmd(ffst_pkg::OP_CLEAR, 6'd21, 32'hFFFF_FFFF);
    add_cmd(ffst_pkg::OP_GET, 6'd0, 32'h0);
    // Zero limit: nothing usable
    add_limit(7'd0);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'hA5A5_A5A5);
    add_cmd(ffst_pkg::OP_GET, 6'd0, 32'h0);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd0, 32'h0);
    // Limit above table size acts as the full table; refill a hole at the bottom
    add_limit(7'd127);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'h8000_0001);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'h7FFF_FFFE);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'h5555_5555);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd1, 32'h0);
    add_cmd(ffst_pkg::OP_APPEND, 6'd0, 32'hAAAA_AAAA);
    add_cmd(ffst_pkg::OP_GET, 6'd1, 32'h0);
    add_cmd(ffst_pkg::OP_GET, 6'd2, 32'h0);
    add_cmd(ffst_pkg::OP_CLEAR, 6'd0, 32'h0);

    // Fill every slot once, hit the full table, then churn at the reset limit
    add_limit(7'd64);
    for (k = 0; k < SLOT_COUNT + 2; k++) add_cmd(ffst_pkg::OP_APPEND, any_index(), pick_word());
    add_cmd(ffst_pkg::OP_GET, 6'd63, 32'h0);
    add_cmd(ffst_pkg::OP_REMOVE, 6'd63, 32'h0);
    add_cmd(ffst_pkg::OP_GET, 6'd63, 32'h0);
    random_phase(7'd64, 100);

    lims = '{7'd2, 7'd63, 7'd5, 7'd33, 7'd1, 7'd17, 7'd127, 7'd8,
             7'd48, 7'd0, 7'd3, 7'd64, 7'd0, 7'd0};
    k = $urandom_range(1, 64);
    lims[12] = k[ffst_pkg::LIMIT_W-1:0];
    k = $urandom_range(1, 127);
    lims[13] = k[ffst_pkg::LIMIT_W-1:0];
    for (k = 0; k < 14; k++) random_phase(lims[k], (lims[k] == 0) ? 20 : 125);

    // Release reset
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: all beats sent, all results back, then let the table settle
    @(posedge clk);
    while (beat_q.size() != 0 || start || cfg_valid || outcome_q.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (outcome_q.size() != 0) note_mismatch("missing results", 0, outcome_q.size());

    $display("Ran %0d commands (append %0d, remove %0d, get %0d, clear %0d),",
             op_seen[ffst_pkg::OP_APPEND] + op_seen[ffst_pkg::OP_REMOVE] +
             op_seen[ffst_pkg::OP_GET] + op_seen[ffst_pkg::OP_CLEAR],
             op_seen[ffst_pkg::OP_APPEND], op_seen[ffst_pkg::OP_REMOVE],
             op_seen[ffst_pkg::OP_GET], op_seen[ffst_pkg::OP_CLEAR]);
    $display("%0d limit writes; status mix: ok %0d, full %0d, out of range %0d,",
             limit_writes, status_seen[ffst_pkg::ST_OK], status_seen[ffst_pkg::ST_FULL],
             status_seen[ffst_pkg::ST_RANGE]);
    $display("not in use %0d; %0d mismatches.", status_seen[ffst_pkg::ST_FREE],
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
